// ----- rtl/tpi_pkg.sv -----
// Shared types, codes and the quarter-wave sine table of the turtle path interpreter.
package tpi_pkg;

   localparam int COORD_W = 24;
   localparam int STEP_W = 16;
   localparam int SYM_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int CFG_DIR_W = 4;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef enum logic [1:0] {
      ST_DRAWN     = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_LENGTH = 3'd0,
      CSR_TURN_UNITS  = 3'd1,
      CSR_START_X     = 3'd2,
      CSR_START_Y     = 3'd3,
      CSR_START_DIR   = 3'd4
   } csr_index_type;

   localparam logic [SYM_W-1:0] SYM_FORWARD = 8'h46;  // F
   localparam logic [SYM_W-1:0] SYM_PLUS    = 8'h2B;  // +
   localparam logic [SYM_W-1:0] SYM_MINUS   = 8'h2D;  // -
   localparam logic [SYM_W-1:0] SYM_PUSH    = 8'h5B;  // [
   localparam logic [SYM_W-1:0] SYM_POP     = 8'h5D;  // ]

   // Stack requests for one executed item.
   typedef struct packed {
      logic restart;
      logic push;
      logic pop;
   } stk_cmd_type;

   // Stack occupancy as it stands before the current item.
   typedef struct packed {
      logic full;
      logic empty;
   } stk_stat_type;

   // round(sin(k*pi/128) * 32768), last entry held at full scale minus one.
   localparam logic [15:0] SIN_QUARTER [65] = '{
      16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
      16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
      16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
      16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
      16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
      16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
      16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
      16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
      16'd32767
   };

   // Sine of a fine angle out of 256 per turn, Q1.15 with sign.
   function automatic logic signed [16:0] fine_sin(input logic [7:0] angle);
      logic [5:0] r;
      logic [1:0] q;
      logic [6:0] idx;
      logic signed [16:0] v;
      r = angle[5:0];
      q = angle[7:6];
      idx = q[0] ? (7'd64 - {1'b0, r}) : {1'b0, r};
      v = $signed({1'b0, SIN_QUARTER[idx]});
      return q[1] ? -v : v;
   endfunction

endpackage

// ----- rtl/tpi_channels.sv -----
// Handshake channel interfaces: symbol requests, segment responses and register writes.
interface tpi_req_if
   import tpi_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             restart;

   modport source(output valid, output symbol, output restart, input ready);
   modport sink(input valid, input symbol, input restart, output ready);
endinterface

interface tpi_rsp_if
   import tpi_pkg::*;
   ();
   logic       valid;
   logic       ready;
   coord_type  from_x;
   coord_type  from_y;
   coord_type  to_x;
   coord_type  to_y;
   logic [1:0] status;

   modport source(output valid, output from_x, output from_y, output to_x, output to_y,
                  output status, input ready);
   modport sink(input valid, input from_x, input from_y, input to_x, input to_y,
                input status, output ready);
endinterface

interface tpi_csr_if
   import tpi_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/turtle_path_interpreter_top.sv -----
// Top level of the turtle path interpreter: input register, turtle state and result register.
//
// The block walks a 2-D turtle over a stream of L-system symbols. Each req beat carries
// one symbol and a restart flag; restart reloads position and heading from the start
// registers and empties the save stack before the symbol acts. 'F' moves forward and
// sends one rsp beat with the drawn segment (status drawn). '+' and '-' turn, '[' saves
// and ']' restores position and heading. A push on a full stack or a pop on an empty one
// is dropped and sends one rsp beat with from equal to to and an overflow or underflow
// status. All other symbols send nothing.
// The csr channel is always ready and writes step length, turn units and the start
// pose; a new start pose only takes effect at the next restart.
// A req beat is registered in the input register and executed from there into the result
// register, which drives its rsp beat. Throughput is one symbol per cycle while the rsp
// side does not stall: the position, heading and stack top are updated each cycle through
// one multiplier per axis, and the stack keeps its top and the entry below in registers
// with the RAM read prefetched.
// When the rsp side stalls, the result register holds, execution waits, and the input
// register absorbs one more beat before req ready drops.
// Reset restores the register reset values, puts the turtle at its start pose and
// empties the stack; no clearing pass is needed.
module turtle_path_interpreter_top
   import tpi_pkg::*;
#(
   parameter int STACK_DEPTH = 32,
   parameter int DIRECTIONS = 16,
   parameter int FRAC_BITS = 8
) (
   input logic        clock,
   input logic        reset,
   tpi_req_if.sink    req_ch,
   tpi_rsp_if.source  rsp_ch,
   tpi_csr_if.sink    csr_ch
);

   localparam int HW = $clog2(DIRECTIONS);
   localparam int EW = 2 * COORD_W + HW;
   localparam int STEP_RAW = 20 << FRAC_BITS;
   localparam logic [STEP_W-1:0] STEP_RST = STEP_W'((STEP_RAW > 65535) ? 65535 : STEP_RAW);
   localparam coord_type START_Y_RST = COORD_W'(-(500 << FRAC_BITS));
   localparam logic [CFG_DIR_W-1:0] START_DIR_RST = 4'd4;
   localparam logic [HW-1:0] DIR_RST = HW'(4 % DIRECTIONS);
   localparam logic [HW:0] DIR_C = (HW + 1)'(DIRECTIONS);

   // Configuration registers.
   logic [STEP_W-1:0]    step_ff;
   logic [CFG_DIR_W-1:0] turn_ff;
   coord_type            start_x_ff, start_y_ff;
   logic [CFG_DIR_W-1:0] start_dir_ff;

   // Input register.
   logic             in_valid_ff, in_valid_in;
   logic [SYM_W-1:0] in_sym_ff;
   logic             in_restart_ff;

   // Turtle state.
   coord_type   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [HW-1:0] head_ff, head_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   coord_type  rsp_from_x_ff, rsp_from_y_ff, rsp_to_x_ff, rsp_to_y_ff;
   coord_type  rsp_from_x_in, rsp_from_y_in, rsp_to_x_in, rsp_to_y_in;
   status_type rsp_status_ff, rsp_status_in;

   logic          exec_go, req_fire, csr_fire;
   coord_type     cur_x, cur_y, move_x, move_y, pop_x, pop_y;
   logic [HW-1:0] cur_head, pop_head, turn_amt;
   logic [HW:0]   head_sum;
   logic          is_fwd, is_plus, is_minus, is_push, is_pop;
   logic          full_now, empty_now;
   stk_cmd_type   stk_cmd;
   stk_stat_type  stk_stat;
   logic [EW-1:0] stk_top;

   // Reduces a 4-bit register value modulo the number of directions.
   function automatic logic [HW-1:0] mod_dir(input logic [CFG_DIR_W-1:0] v);
      logic [8:0] r;
      r = {5'd0, v};
      for (int i = 0; i < 3; i++) begin
         if (r >= 9'(DIRECTIONS)) begin
            r = r - 9'(DIRECTIONS);
         end
      end
      return r[HW-1:0];
   endfunction

   assign exec_go = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || exec_go;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_fire = csr_ch.valid;

   // Pose that the symbol acts on, after an optional restart.
   assign cur_x = in_restart_ff ? start_x_ff : pos_x_ff;
   assign cur_y = in_restart_ff ? start_y_ff : pos_y_ff;
   assign cur_head = in_restart_ff ? mod_dir(start_dir_ff) : head_ff;
   assign turn_amt = mod_dir(turn_ff);

   always_comb begin
      is_fwd = 1'b0;
      is_plus = 1'b0;
      is_minus = 1'b0;
      is_push = 1'b0;
      is_pop = 1'b0;
      case (in_sym_ff)
         SYM_FORWARD: is_fwd = 1'b1;
         SYM_PLUS:    is_plus = 1'b1;
         SYM_MINUS:   is_minus = 1'b1;
         SYM_PUSH:    is_push = 1'b1;
         SYM_POP:     is_pop = 1'b1;
         default:     ;
      endcase
   end

   assign full_now = !in_restart_ff && stk_stat.full;
   assign empty_now = in_restart_ff || stk_stat.empty;

   assign stk_cmd.restart = exec_go && in_restart_ff;
   assign stk_cmd.push = exec_go && is_push;
   assign stk_cmd.pop = exec_go && is_pop;

   tpi_stack #(
      .DEPTH(STACK_DEPTH),
      .WIDTH(EW)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .cmd      (stk_cmd),
      .push_data({cur_x, cur_y, cur_head}),
      .top_data (stk_top),
      .stat     (stk_stat)
   );

   assign pop_x = stk_top[EW-1 -: COORD_W];
   assign pop_y = stk_top[HW +: COORD_W];
   assign pop_head = stk_top[HW-1:0];

   tpi_mover #(
      .DIRECTIONS(DIRECTIONS)
   ) u_mover (
      .heading    (cur_head),
      .step_length(step_ff),
      .from_x     (cur_x),
      .from_y     (cur_y),
      .to_x       (move_x),
      .to_y       (move_y)
   );

   always_comb begin
      // Turns stay below twice the direction count, so one subtract wraps them.
      head_sum = {1'b0, cur_head};
      if (is_plus) begin
         head_sum = {1'b0, cur_head} + {1'b0, turn_amt};
      end else if (is_minus) begin
         head_sum = {1'b0, cur_head} + (DIR_C - {1'b0, turn_amt});
      end
      if (head_sum >= DIR_C) begin
         head_sum = head_sum - DIR_C;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (exec_go) begin
         in_valid_in = 1'b0;
      end

      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      head_in = head_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_from_x_in = rsp_from_x_ff;
      rsp_from_y_in = rsp_from_y_ff;
      rsp_to_x_in = rsp_to_x_ff;
      rsp_to_y_in = rsp_to_y_ff;
      rsp_status_in = rsp_status_ff;

      if (exec_go) begin
         pos_x_in = cur_x;
         pos_y_in = cur_y;
         head_in = head_sum[HW-1:0];
         rsp_from_x_in = cur_x;
         rsp_from_y_in = cur_y;
         rsp_to_x_in = cur_x;
         rsp_to_y_in = cur_y;
         if (is_fwd) begin
            pos_x_in = move_x;
            pos_y_in = move_y;
            rsp_to_x_in = move_x;
            rsp_to_y_in = move_y;
            rsp_status_in = ST_DRAWN;
            rsp_valid_in = 1'b1;
         end else if (is_push && full_now) begin
            rsp_status_in = ST_OVERFLOW;
            rsp_valid_in = 1'b1;
         end else if (is_pop && empty_now) begin
            rsp_status_in = ST_UNDERFLOW;
            rsp_valid_in = 1'b1;
         end else if (is_pop) begin
            pos_x_in = pop_x;
            pos_y_in = pop_y;
            head_in = pop_head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RST;
         turn_ff <= 4'd1;
         start_x_ff <= '0;
         start_y_ff <= START_Y_RST;
         start_dir_ff <= START_DIR_RST;
         in_valid_ff <= 1'b0;
         pos_x_ff <= '0;
         pos_y_ff <= START_Y_RST;
         head_ff <= DIR_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            case (csr_index_type'(csr_ch.index))
               CSR_STEP_LENGTH: step_ff <= csr_ch.data[STEP_W-1:0];
               CSR_TURN_UNITS:  turn_ff <= csr_ch.data[CFG_DIR_W-1:0];
               CSR_START_X:     start_x_ff <= csr_ch.data;
               CSR_START_Y:     start_y_ff <= csr_ch.data;
               CSR_START_DIR:   start_dir_ff <= csr_ch.data[CFG_DIR_W-1:0];
               default:         ;
            endcase
         end
         in_valid_ff <= in_valid_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         head_ff <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         in_sym_ff <= req_ch.symbol;
         in_restart_ff <= req_ch.restart;
      end
      rsp_from_x_ff <= rsp_from_x_in;
      rsp_from_y_ff <= rsp_from_y_in;
      rsp_to_x_ff <= rsp_to_x_in;
      rsp_to_y_ff <= rsp_to_y_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.from_x = rsp_from_x_ff;
   assign rsp_ch.from_y = rsp_from_y_ff;
   assign rsp_ch.to_x = rsp_to_x_ff;
   assign rsp_ch.to_y = rsp_to_y_ff;
   assign rsp_ch.status = rsp_status_ff;

   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_OVERFLOW |-> stk_stat.full)
      else $error("overflow reported while the stack has room");

   a_underflow_empty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_UNDERFLOW |-> stk_stat.empty)
      else $error("underflow reported while the stack holds entries");

   a_forward_draws : assert property (@(posedge clock) disable iff (reset)
      exec_go && is_fwd |=> rsp_valid_ff && rsp_status_ff == ST_DRAWN
                            && rsp_to_x_ff == pos_x_ff && rsp_to_y_ff == pos_y_ff)
      else $error("forward move did not produce a matching segment");

endmodule

// ----- rtl/tpi_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tpi_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tpi_stack.sv -----
// Save stack: top entry and the one below it in registers, the rest in RAM.
module tpi_stack
   import tpi_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int WIDTH = 52
) (
   input  logic             clock,
   input  logic             reset,
   input  stk_cmd_type      cmd,
   input  logic [WIDTH-1:0] push_data,
   output logic [WIDTH-1:0] top_data,
   output stk_stat_type     stat
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   logic [CW-1:0]    count_ff, count_in, count_base, count_m2;
   logic [WIDTH-1:0] top_ff, top_in;
   logic [WIDTH-1:0] below_ff, below_in, below;
   logic             use_ram_ff, use_ram_in;
   logic             do_push, do_pop, ram_wr;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [WIDTH-1:0] rd_data;

   // The entry under the top is either the old top kept right after a push,
   // or the RAM word prefetched at the new depth after a pop.
   assign below = use_ram_ff ? rd_data : below_ff;

   always_comb begin
      count_base = cmd.restart ? '0 : count_ff;
      do_push = cmd.push && (count_base != DEPTH_C);
      do_pop = cmd.pop && (count_base != '0);
      count_in = count_base;
      top_in = top_ff;
      below_in = below_ff;
      use_ram_in = use_ram_ff;
      ram_wr = 1'b0;
      if (do_push) begin
         count_in = count_base + CW'(1);
         top_in = push_data;
         below_in = top_ff;
         use_ram_in = 1'b0;
         ram_wr = (count_base != '0);
      end else if (do_pop) begin
         count_in = count_base - CW'(1);
         top_in = below;
         use_ram_in = 1'b1;
      end
      count_m2 = count_in - CW'(2);
   end

   assign wr_addr = AW'(count_base - CW'(1));
   assign rd_addr = count_m2[AW-1:0];

   tpi_ram #(
      .WIDTH(WIDTH),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(wr_addr),
      .wr_data(top_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         use_ram_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         use_ram_ff <= use_ram_in;
      end
      top_ff <= top_in;
      below_ff <= below_in;
   end

   assign top_data = top_ff;
   assign stat.full = (count_ff == DEPTH_C);
   assign stat.empty = (count_ff == '0);

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("stack depth beyond capacity");

   a_restart_empties : assert property (@(posedge clock) disable iff (reset)
      cmd.restart && !cmd.push |=> stat.empty)
      else $error("restart left entries on the stack");

   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      do_push |=> count_ff == $past(count_base) + CW'(1) && top_ff == $past(push_data))
      else $error("push did not land on top of the stack");

endmodule

// ----- rtl/tpi_mover.sv -----
// Forward move: heading to sine and cosine, scaled by step length, saturating add.
module tpi_mover
   import tpi_pkg::*;
#(
   parameter int DIRECTIONS = 16
) (
   input  logic [$clog2(DIRECTIONS)-1:0] heading,
   input  logic [STEP_W-1:0]             step_length,
   input  coord_type                     from_x,
   input  coord_type                     from_y,
   output coord_type                     to_x,
   output coord_type                     to_y
);

   logic [7:0]         angle_tab [DIRECTIONS];
   logic [7:0]         angle;
   logic signed [16:0] cos_v, sin_v;
   logic signed [33:0] prod_x, prod_y;
   logic signed [34:0] round_x, round_y;
   logic signed [19:0] delta_x, delta_y;
   logic signed [25:0] sum_x, sum_y;

   // Fine angle out of 256 per turn for each heading.
   for (genvar k = 0; k < DIRECTIONS; k++) begin : g_angle
      assign angle_tab[k] = 8'((k * 256) / DIRECTIONS);
   end

   function automatic coord_type sat_coord(input logic signed [25:0] s);
      if (s > 26'sd8388607) begin
         return coord_type'(24'h7FFFFF);
      end else if (s < -26'sd8388608) begin
         return coord_type'(24'h800000);
      end
      return s[23:0];
   endfunction

   always_comb begin
      angle = angle_tab[heading];
      cos_v = fine_sin(angle + 8'd64);
      sin_v = fine_sin(angle);
      prod_x = $signed({1'b0, step_length}) * cos_v;
      prod_y = $signed({1'b0, step_length}) * sin_v;
      // Round half up, then drop the fifteen fraction bits of the table.
      round_x = {prod_x[33], prod_x} + 35'sd16384;
      round_y = {prod_y[33], prod_y} + 35'sd16384;
      delta_x = round_x[34:15];
      delta_y = round_y[34:15];
      sum_x = {{2{from_x[23]}}, from_x} + {{6{delta_x[19]}}, delta_x};
      sum_y = {{2{from_y[23]}}, from_y} + {{6{delta_y[19]}}, delta_y};
      to_x = sat_coord(sum_x);
      to_y = sat_coord(sum_y);
   end

endmodule
